### hw/rtl/bscmm_pkg.sv
// ----------------------------------------------------------------------------
// bscmm_pkg: shared types and constants of the banked sound CPU memory map
// Transaction payload structs, access mode codes, bus decode constants and
// the read source select used by the memory map unit.
// ----------------------------------------------------------------------------
package bscmm_pkg;

   // RAM geometry (both work RAM and high RAM)
   localparam int RAM_BYTES = 4096;
   localparam int RAM_AW    = $clog2(RAM_BYTES);

   // Access modes
   localparam logic [2:0] MODE_DATA_READ = 3'd0;
   localparam logic [2:0] MODE_FETCH     = 3'd1;
   localparam logic [2:0] MODE_WRITE     = 3'd2;
   localparam logic [2:0] MODE_PORT_READ = 3'd3;
   localparam logic [2:0] MODE_ROM_LOAD  = 3'd4;

   // Bus decode constants
   localparam logic [15:0] BANK_WIN_BASE = 16'h8000;
   localparam logic [15:0] WORK_RAM_BASE = 16'hC000;
   localparam logic [15:0] WORK_RAM_TOP  = 16'hCFFF;
   localparam logic [15:0] SOUND_BASE    = 16'hD000;
   localparam logic [15:0] SOUND_TOP     = 16'hD002;
   localparam logic [15:0] BANK_SEL_ADDR = 16'hD003;
   localparam logic [15:0] STATUS_ADDR   = 16'hD007;
   localparam logic [15:0] HIGH_RAM_BASE = 16'hF000;

   // ROM positions
   localparam logic [19:0] DECRYPT_OFFSET = 20'h40000;
   localparam logic [19:0] PORT_ROM_POS   = 20'h00011;

   // Bank select: 0x8000 + nibble * 0x4000, i.e. (nibble + 2) in 16 KB units
   localparam logic [4:0] BANK_BASE_UNITS = 5'd2;
   localparam logic [3:0] BANK_NIB_OVER   = 4'hF;   // lands above 256K

   // Read source of a result
   typedef enum logic [2:0] {
      SRC_ZERO   = 3'd0,
      SRC_ROM    = 3'd1,
      SRC_WORK   = 3'd2,
      SRC_HIGH   = 3'd3,
      SRC_STATUS = 3'd4
   } src_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic [15:0] address;
      logic [7:0]  write_data;
      logic [18:0] rom_index;
      logic [7:0]  sound_status;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       sound_write_valid;
      logic [1:0] sound_register;
      logic [7:0] sound_write_data;
   } rsp_type;

endpackage

### hw/rtl/banked_sound_cpu_memory_map_unit.sv
// ----------------------------------------------------------------------------
// banked_sound_cpu_memory_map_unit: bus decoder of an 8-bit sound CPU
// Holds the ROM image, work RAM, high RAM and the ROM bank offset, and
// answers one bus access per transaction.
// ----------------------------------------------------------------------------
//
//  channel   ports                          handshake
//  -------   -----------------------------  ---------------------------------
//  request   start, busy, req_payload       taken when start && !busy
//  response  rsp_strobe, rsp_payload        valid one cycle, no back-pressure
//  config    csr_write_enable, csr_write_data  written when enable is high
//
//  One transaction per cycle while busy is low; each result appears in the cycle
//  after its request, set by the registered read of the ROM and RAM arrays.
//  Work RAM and high RAM share one array: work RAM in the lower half, high RAM
//  in the upper half. After reset busy stays high while that array is cleared,
//  one entry per cycle; config writes are taken during that pass.
//  The receiver cannot stall, so busy is never raised by the response side.
//
module banked_sound_cpu_memory_map_unit #(
   parameter int ROM_BYTES = 524288
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  bscmm_pkg::req_type  req_payload,
   output logic                rsp_strobe,
   output bscmm_pkg::rsp_type  rsp_payload,
   input  logic                csr_write_enable,
   input  logic                csr_write_data
);

   localparam int          ROM_AW    = $clog2(ROM_BYTES);
   localparam logic [20:0] ROM_LIMIT = 21'(ROM_BYTES);
   localparam int          RAM_DEPTH = 2 * bscmm_pkg::RAM_BYTES;
   localparam int          RAM_IW    = bscmm_pkg::RAM_AW + 1;
   localparam logic [RAM_IW-1:0] RAM_LAST = {RAM_IW{1'b1}};

   // Memories
   logic [7:0] rom_mem  [ROM_BYTES];
   logic [7:0] ram_mem  [RAM_DEPTH];

   // Control registers
   logic                          clear_ff, clear_in;
   logic [RAM_IW-1:0]             clear_cnt_ff, clear_cnt_in;
   logic [18:0]                   bank_ff, bank_in;
   logic                          decrypt_ff;
   logic                          rsp_valid_ff;

   // Result registers
   bscmm_pkg::src_type src_ff, src_in;
   logic [7:0]         status_ff;
   logic               svalid_ff, svalid_in;
   logic [1:0]         sreg_ff, sreg_in;
   logic [7:0]         sdata_ff, sdata_in;
   logic [7:0]         rom_q, ram_q;

   // Decode signals
   logic                          accept;
   logic [15:0]                   addr;
   logic [19:0]                   rom_pos;
   logic [ROM_AW-1:0]             rom_wa;
   logic                          rom_rd;
   logic                          rom_we;
   logic                          work_we, high_we;
   logic                          ram_we;
   logic [RAM_IW-1:0]             ram_ra;
   logic [RAM_IW-1:0]             ram_wa;
   logic [7:0]                    ram_wd;
   logic [4:0]                    bank_units;

   assign busy   = clear_ff;
   assign accept = start && !clear_ff;
   assign addr   = req_payload.address;
   assign rom_wa = ROM_AW'(req_payload.rom_index);

   // Map the bus address onto the shared RAM array, high RAM in the upper half
   assign ram_ra = {(addr >= bscmm_pkg::HIGH_RAM_BASE), addr[bscmm_pkg::RAM_AW-1:0]};

   // Decode the transaction
   always_comb begin
      src_in     = bscmm_pkg::SRC_ZERO;
      rom_pos    = bscmm_pkg::PORT_ROM_POS;
      rom_rd     = 1'b0;
      rom_we     = 1'b0;
      work_we    = 1'b0;
      high_we    = 1'b0;
      svalid_in  = 1'b0;
      sreg_in    = 2'd0;
      sdata_in   = 8'd0;
      bank_in    = bank_ff;
      bank_units = 5'(req_payload.write_data[3:0]) + bscmm_pkg::BANK_BASE_UNITS;
      case (req_payload.mode)
         bscmm_pkg::MODE_DATA_READ, bscmm_pkg::MODE_FETCH: begin
            if (req_payload.mode == bscmm_pkg::MODE_FETCH && decrypt_ff
                  && addr < bscmm_pkg::BANK_WIN_BASE) begin
               rom_pos = bscmm_pkg::DECRYPT_OFFSET | 20'(addr[14:0]);
               rom_rd  = 1'b1;
            end else if (addr < bscmm_pkg::BANK_WIN_BASE) begin
               rom_pos = 20'(addr);
               rom_rd  = 1'b1;
            end else if (addr < bscmm_pkg::WORK_RAM_BASE) begin
               rom_pos = 20'(bank_ff) + 20'(addr[13:0]);
               rom_rd  = 1'b1;
            end else if (addr <= bscmm_pkg::WORK_RAM_TOP) begin
               src_in = bscmm_pkg::SRC_WORK;
            end else if (addr == bscmm_pkg::STATUS_ADDR) begin
               src_in = bscmm_pkg::SRC_STATUS;
            end else if (addr >= bscmm_pkg::HIGH_RAM_BASE) begin
               src_in = bscmm_pkg::SRC_HIGH;
            end
         end
         bscmm_pkg::MODE_WRITE: begin
            if (addr >= bscmm_pkg::WORK_RAM_BASE && addr <= bscmm_pkg::WORK_RAM_TOP) begin
               work_we = 1'b1;
            end else if (addr >= bscmm_pkg::SOUND_BASE && addr <= bscmm_pkg::SOUND_TOP) begin
               svalid_in = 1'b1;
               sreg_in   = addr[1:0];
               sdata_in  = req_payload.write_data;
            end else if (addr == bscmm_pkg::BANK_SEL_ADDR) begin
               if (req_payload.write_data[3:0] == bscmm_pkg::BANK_NIB_OVER) begin
                  bank_in = 19'd0;
               end else begin
                  bank_in = {bank_units, 14'd0};
               end
            end else if (addr >= bscmm_pkg::HIGH_RAM_BASE) begin
               high_we = 1'b1;
            end
         end
         bscmm_pkg::MODE_PORT_READ: begin
            rom_pos = bscmm_pkg::PORT_ROM_POS;
            rom_rd  = 1'b1;
         end
         bscmm_pkg::MODE_ROM_LOAD: begin
            rom_we = ({2'b00, req_payload.rom_index} < ROM_LIMIT);
         end
         default: begin
         end
      endcase
      // Drop ROM reads beyond the image
      if (rom_rd && ({1'b0, rom_pos} < ROM_LIMIT)) begin
         src_in = bscmm_pkg::SRC_ROM;
      end
   end

   // Clearing pass over the RAM array
   always_comb begin
      clear_in     = clear_ff;
      clear_cnt_in = clear_cnt_ff;
      if (clear_ff) begin
         clear_cnt_in = clear_cnt_ff + 1'b1;
         if (clear_cnt_ff == RAM_LAST) begin
            clear_in = 1'b0;
         end
      end
   end

   // Select RAM write port source: clearing pass or CPU write
   always_comb begin
      ram_we = clear_ff || (accept && (work_we || high_we));
      if (clear_ff) begin
         ram_wa = clear_cnt_ff;
         ram_wd = 8'd0;
      end else begin
         ram_wa = ram_ra;
         ram_wd = req_payload.write_data;
      end
   end

   // ROM array: load writes, registered read
   always_ff @(posedge clock) begin
      if (accept && rom_we) begin
         rom_mem[rom_wa] <= req_payload.write_data;
      end
      rom_q <= rom_mem[rom_pos[ROM_AW-1:0]];
   end

   // RAM array: work RAM and high RAM
   always_ff @(posedge clock) begin
      if (ram_we) begin
         ram_mem[ram_wa] <= ram_wd;
      end
      ram_q <= ram_mem[ram_ra];
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff     <= 1'b1;
         clear_cnt_ff <= '0;
         bank_ff      <= 19'd0;
         decrypt_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clear_ff     <= clear_in;
         clear_cnt_ff <= clear_cnt_in;
         rsp_valid_ff <= accept;
         if (accept) begin
            bank_ff <= bank_in;
         end
         if (csr_write_enable) begin
            decrypt_ff <= csr_write_data;
         end
      end
   end

   // Hold result fields of the accepted transaction
   always_ff @(posedge clock) begin
      if (accept) begin
         src_ff    <= src_in;
         status_ff <= req_payload.sound_status;
         svalid_ff <= svalid_in;
         sreg_ff   <= sreg_in;
         sdata_ff  <= sdata_in;
      end
   end

   // Drive the response
   assign rsp_strobe = rsp_valid_ff;
   always_comb begin
      case (src_ff)
         bscmm_pkg::SRC_ROM:    rsp_payload.read_data = rom_q;
         bscmm_pkg::SRC_WORK:   rsp_payload.read_data = ram_q;
         bscmm_pkg::SRC_HIGH:   rsp_payload.read_data = ram_q;
         bscmm_pkg::SRC_STATUS: rsp_payload.read_data = status_ff;
         default:               rsp_payload.read_data = 8'd0;
      endcase
      rsp_payload.sound_write_valid = svalid_ff;
      rsp_payload.sound_register    = sreg_ff;
      rsp_payload.sound_write_data  = sdata_ff;
   end

`ifndef SYNTHESIS
   // A response follows exactly one accepted request
   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy))
      else $error("response without accepted request");

   // Clearing pass ends only after the last RAM entry
   a_clear_complete: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> $past(clear_cnt_ff) == RAM_LAST)
      else $error("clearing pass ended early");

   // Sound fields are zero when no sound write
   a_sound_idle_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_payload.sound_write_valid) |->
         (rsp_payload.sound_register == 2'd0 && rsp_payload.sound_write_data == 8'd0))
      else $error("sound fields set without sound write");

   // A sound write returns no read data
   a_sound_no_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.sound_write_valid) |-> rsp_payload.read_data == 8'd0)
      else $error("read data on sound write");
`endif

endmodule

### sim/banked_sound_cpu_memory_map_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// banked_sound_cpu_memory_map_checker: bus result checker of the memory map
// Watches the request, response and register ports of the memory map unit,
// keeps its own copy of the ROM image, both RAMs, the bank offset and the
// decrypt flag, and compares every response field against the predicted one.
// ----------------------------------------------------------------------------
module banked_sound_cpu_memory_map_checker
   import bscmm_pkg::*;
#(
   parameter int ROM_BYTES = 524288
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_payload,
   input  logic    rsp_strobe,
   input  rsp_type rsp_payload,
   input  logic    csr_write_enable,
   input  logic    csr_write_data,
   output int      mismatch_count,
   output int      pending_count
);

   localparam int          MAX_REPORTS  = 10;
   localparam int unsigned BANK_STEP    = 32'h4000;
   localparam int unsigned BANK_CEILING = 32'h40000;

   logic [7:0]  rom_image     [ROM_BYTES];
   logic [7:0]  work_ram_copy [RAM_BYTES];
   logic [7:0]  high_ram_copy [RAM_BYTES];
   int unsigned bank_offset_copy;
   logic        decrypt_copy;
   rsp_type     expected_bus_results [$];
   rsp_type     want;

   // ROM byte at an image position, zero beyond the image
   function automatic logic [7:0] rom_at(input int unsigned pos);
      if (pos < ROM_BYTES) return rom_image[pos];
      return 8'h00;
   endfunction

   // data side decode of a read address
   function automatic logic [7:0] bus_read(input logic [15:0] addr, input logic [7:0] status);
      if (addr < BANK_WIN_BASE) return rom_at(addr);
      if (addr < WORK_RAM_BASE) return rom_at(int'(addr - BANK_WIN_BASE) + bank_offset_copy);
      if (addr <= WORK_RAM_TOP) return work_ram_copy[addr[RAM_AW-1:0]];
      if (addr == STATUS_ADDR) return status;
      if (addr >= HIGH_RAM_BASE) return high_ram_copy[addr[RAM_AW-1:0]];
      return 8'h00;
   endfunction

   // apply one bus access to the state copy and return its result
   function automatic rsp_type model_bus_access(input req_type acc);
      rsp_type     res;
      int unsigned bank_pick;
      res = '0;
      case (acc.mode)
         MODE_DATA_READ: res.read_data = bus_read(acc.address, acc.sound_status);
         MODE_FETCH: begin
            if (decrypt_copy && acc.address < BANK_WIN_BASE)
               res.read_data = rom_at(int'(acc.address) + int'(DECRYPT_OFFSET));
            else
               res.read_data = bus_read(acc.address, acc.sound_status);
         end
         MODE_WRITE: begin
            if (acc.address >= WORK_RAM_BASE && acc.address <= WORK_RAM_TOP) begin
               work_ram_copy[acc.address[RAM_AW-1:0]] = acc.write_data;
            end else if (acc.address >= SOUND_BASE && acc.address <= SOUND_TOP) begin
               res.sound_write_valid = 1'b1;
               res.sound_register    = acc.address[1:0];
               res.sound_write_data  = acc.write_data;
            end else if (acc.address == BANK_SEL_ADDR) begin
               bank_pick = int'(BANK_WIN_BASE) + acc.write_data[3:0] * BANK_STEP;
               bank_offset_copy = (bank_pick > BANK_CEILING) ? 0 : bank_pick;
            end else if (acc.address >= HIGH_RAM_BASE) begin
               high_ram_copy[acc.address[RAM_AW-1:0]] = acc.write_data;
            end
         end
         MODE_PORT_READ: res.read_data = rom_at(int'(PORT_ROM_POS));
         MODE_ROM_LOAD: begin
            if (acc.rom_index < ROM_BYTES) rom_image[acc.rom_index] = acc.write_data;
         end
         default: ;
      endcase
      return res;
   endfunction

   // compare responses, track register writes, predict accepted requests
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RAM_BYTES; i++) begin
            work_ram_copy[i] = 8'h00;
            high_ram_copy[i] = 8'h00;
         end
         bank_offset_copy = 0;
         decrypt_copy     = 1'b0;
         mismatch_count   = 0;
         expected_bus_results.delete();
      end else begin
         if (rsp_strobe) begin
            if (expected_bus_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("[%0t] response with no transaction outstanding: rd=%02h sv=%0b reg=%0d sd=%02h",
                           $time, rsp_payload.read_data, rsp_payload.sound_write_valid,
                           rsp_payload.sound_register, rsp_payload.sound_write_data);
            end else begin
               want = expected_bus_results.pop_front();
               if (rsp_payload.read_data !== want.read_data ||
                   rsp_payload.sound_write_valid !== want.sound_write_valid ||
                   rsp_payload.sound_register !== want.sound_register ||
                   rsp_payload.sound_write_data !== want.sound_write_data) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS)
                     $display("[%0t] response mismatch: expected rd=%02h sv=%0b reg=%0d sd=%02h, got rd=%02h sv=%0b reg=%0d sd=%02h",
                              $time, want.read_data, want.sound_write_valid,
                              want.sound_register, want.sound_write_data,
                              rsp_payload.read_data, rsp_payload.sound_write_valid,
                              rsp_payload.sound_register, rsp_payload.sound_write_data);
               end
            end
         end
         if (csr_write_enable) decrypt_copy = csr_write_data;
         if (start && !busy) expected_bus_results.push_back(model_bus_access(req_payload));
      end
      pending_count = expected_bus_results.size();
   end

endmodule

### sim/banked_sound_cpu_memory_map_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// banked_sound_cpu_memory_map_unit_test: testbench of the sound CPU memory map
// Drives directed and random bus accesses in bursts with random gaps, changes
// the decrypt flag between drained phases, and lets the checker compare every
// response; never reads a ROM byte before it has been loaded.
// ----------------------------------------------------------------------------
module banked_sound_cpu_memory_map_unit_test;
   import bscmm_pkg::*;

   localparam int         ROM_BYTES        = 524288;
   localparam int         CYCLE_LIMIT      = 200000;
   localparam int         RANDOM_PHASES    = 4;
   localparam int         PHASE_ITEMS      = 140;
   localparam logic [2:0] MODE_UNUSED_LAST = 3'd7;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_payload;
   logic    rsp_strobe;
   rsp_type rsp_payload;
   logic    csr_write_enable;
   logic    csr_write_data;
   int      mismatch_count;
   int      pending_count;
   int      cycle_count = 0;

   bit          rom_loaded [ROM_BYTES];
   int unsigned bank_now;
   bit          decrypt_now;
   int          burst_left;

   banked_sound_cpu_memory_map_unit #(
      .ROM_BYTES(ROM_BYTES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_payload(req_payload),
      .rsp_strobe(rsp_strobe),
      .rsp_payload(rsp_payload),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   banked_sound_cpu_memory_map_checker #(
      .ROM_BYTES(ROM_BYTES)
   ) result_checker (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_payload(req_payload),
      .rsp_strobe(rsp_strobe),
      .rsp_payload(rsp_payload),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .mismatch_count(mismatch_count),
      .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic req_type make_item(input logic [2:0] mode, input logic [15:0] addr,
                                         input logic [7:0] wdata, input logic [18:0] idx,
                                         input logic [7:0] status);
      req_type item;
      item.mode         = mode;
      item.address      = addr;
      item.write_data   = wdata;
      item.rom_index    = idx;
      item.sound_status = status;
      return item;
   endfunction

   // access with random filler in the fields it does not use
   function automatic req_type noise_item(input logic [2:0] mode, input logic [15:0] addr);
      return make_item(mode, addr, 8'($urandom_range(0, 8'hFF)),
                       19'($urandom_range(0, ROM_BYTES - 1)), 8'($urandom_range(0, 8'hFF)));
   endfunction

   // ROM image position an access reads, or -1 when it reads no ROM
   function automatic int rom_read_pos(input req_type item);
      case (item.mode)
         MODE_PORT_READ: return int'(PORT_ROM_POS);
         MODE_DATA_READ, MODE_FETCH: begin
            if (item.mode == MODE_FETCH && decrypt_now && item.address < BANK_WIN_BASE)
               return int'(item.address) + int'(DECRYPT_OFFSET);
            if (item.address < BANK_WIN_BASE) return int'(item.address);
            if (item.address < WORK_RAM_BASE)
               return int'(item.address - BANK_WIN_BASE) + int'(bank_now);
            return -1;
         end
         default: return -1;
      endcase
   endfunction

   // present one transaction, hold until taken, then pace the burst
   task automatic put_on_bus(input req_type item);
      int unsigned bank_pick;
      start       <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (item.mode == MODE_ROM_LOAD) rom_loaded[item.rom_index] = 1'b1;
      if (item.mode == MODE_WRITE && item.address == BANK_SEL_ADDR) begin
         bank_pick = int'(BANK_WIN_BASE) + item.write_data[3:0] * 32'h4000;
         bank_now  = (bank_pick > 32'h40000) ? 0 : bank_pick;
      end
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         start <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
      end
   endtask

   // load the ROM byte an access needs first, if it is still empty
   task automatic send_access(input req_type item);
      int pos;
      pos = rom_read_pos(item);
      if (pos >= 0 && pos < ROM_BYTES && !rom_loaded[pos])
         put_on_bus(make_item(MODE_ROM_LOAD, 16'($urandom_range(0, 16'hFFFF)),
                              8'($urandom_range(0, 8'hFF)), 19'(pos),
                              8'($urandom_range(0, 8'hFF))));
      put_on_bus(item);
   endtask

   // drop start and hold until every response has come back
   task automatic wait_for_results();
      start <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic write_decrypt(input bit value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      decrypt_now = value;
   endtask

   // field extremes, every mode and the decode corner cases
   task automatic directed_part();
      send_access(make_item(MODE_ROM_LOAD, 16'h0000, 8'hA5, 19'h00011, 8'h00));
      send_access(make_item(MODE_ROM_LOAD, 16'hFFFF, 8'hFF, 19'h00000, 8'hFF));
      send_access(make_item(MODE_ROM_LOAD, 16'h0000, 8'h01, 19'h07FFF, 8'h00));
      send_access(make_item(MODE_ROM_LOAD, 16'h0000, 8'h5A, 19'h40000, 8'h00));
      send_access(make_item(MODE_ROM_LOAD, 16'h0000, 8'h80, 19'h47FFF, 8'h00));
      send_access(make_item(MODE_ROM_LOAD, 16'h0000, 8'h3C, 19'h43FFF, 8'h00));
      send_access(make_item(MODE_ROM_LOAD, 16'h0000, 8'hC3, 19'h7FFFF, 8'h00));
      send_access(make_item(MODE_DATA_READ, 16'h0000, 8'h00, 19'h00000, 8'h00));
      send_access(make_item(MODE_DATA_READ, 16'h7FFF, 8'hFF, 19'h7FFFF, 8'hFF));
      // port read ignores the address
      send_access(make_item(MODE_PORT_READ, 16'hFFFF, 8'h00, 19'h00000, 8'h00));
      send_access(make_item(MODE_FETCH, 16'h0000, 8'h00, 19'h00000, 8'h00));
      // highest legal bank, then the one that wraps to zero
      send_access(make_item(MODE_WRITE, BANK_SEL_ADDR, 8'hFE, 19'h00000, 8'h00));
      send_access(make_item(MODE_DATA_READ, 16'h8000, 8'h00, 19'h00000, 8'h00));
      send_access(make_item(MODE_DATA_READ, 16'hBFFF, 8'h00, 19'h00000, 8'h00));
      send_access(make_item(MODE_WRITE, BANK_SEL_ADDR, 8'h0F, 19'h00000, 8'h00));
      send_access(make_item(MODE_DATA_READ, 16'h8000, 8'h00, 19'h00000, 8'h00));
      send_access(make_item(MODE_WRITE, WORK_RAM_BASE, 8'h12, 19'h00000, 8'h00));
      send_access(make_item(MODE_DATA_READ, WORK_RAM_BASE, 8'h00, 19'h00000, 8'h00));
      send_access(make_item(MODE_DATA_READ, WORK_RAM_TOP, 8'h00, 19'h00000, 8'h00));
      send_access(make_item(MODE_WRITE, 16'hFFFF, 8'hEE, 19'h00000, 8'h00));
      send_access(make_item(MODE_FETCH, 16'hFFFF, 8'h00, 19'h00000, 8'h00));
      send_access(make_item(MODE_WRITE, SOUND_BASE, 8'h00, 19'h00000, 8'h00));
      send_access(make_item(MODE_WRITE, SOUND_TOP, 8'hFF, 19'h00000, 8'h00));
      send_access(make_item(MODE_DATA_READ, STATUS_ADDR, 8'h00, 19'h00000, 8'hFF));
      send_access(make_item(MODE_DATA_READ, 16'hEFFF, 8'h00, 19'h00000, 8'h00));
      send_access(make_item(MODE_UNUSED_LAST, 16'hFFFF, 8'hFF, 19'h7FFFF, 8'hFF));
   endtask

   // mostly decoded accesses with random content, some noise
   task automatic random_phase(input int count);
      int          pick;
      int unsigned ram_off;
      logic [15:0] addr;
      logic [15:0] ram_base;
      logic [2:0]  rd_mode;
      req_type     item;
      repeat (count) begin
         pick     = $urandom_range(0, 99);
         addr     = 16'($urandom_range(0, 16'hFFFF));
         ram_off  = $urandom_range(0, 1) ? $urandom_range(0, 31)
                                         : $urandom_range(0, RAM_BYTES - 1);
         ram_base = $urandom_range(0, 1) ? WORK_RAM_BASE : HIGH_RAM_BASE;
         rd_mode  = $urandom_range(0, 1) ? MODE_DATA_READ : MODE_FETCH;
         if (pick < 14) begin
            item = noise_item(MODE_ROM_LOAD, addr);
            case ($urandom_range(0, 3))
               0: item.rom_index = 19'($urandom_range(0, 16'h7FFF));
               1: item.rom_index = 19'(bank_now + $urandom_range(0, 16'h3FFF));
               2: item.rom_index = 19'(int'(DECRYPT_OFFSET) + $urandom_range(0, 16'h7FFF));
               default: ;
            endcase
            send_access(item);
         end else if (pick < 30) begin
            send_access(noise_item(rd_mode, 16'($urandom_range(0, 16'hBFFF))));
         end else if (pick < 40) begin
            send_access(noise_item(rd_mode, addr));
         end else if (pick < 55) begin
            send_access(noise_item(MODE_WRITE, ram_base + 16'(ram_off)));
         end else if (pick < 67) begin
            send_access(noise_item(rd_mode, ram_base + 16'(ram_off)));
         end else if (pick < 72) begin
            send_access(noise_item(MODE_WRITE, BANK_SEL_ADDR));
         end else if (pick < 77) begin
            send_access(noise_item(MODE_WRITE, SOUND_BASE + 16'($urandom_range(0, 2))));
         end else if (pick < 81) begin
            send_access(noise_item(rd_mode, STATUS_ADDR));
         end else if (pick < 86) begin
            send_access(noise_item(3'($urandom_range(MODE_DATA_READ, MODE_WRITE)),
                                   SOUND_BASE + 16'($urandom_range(0, 16'h1FFF))));
         end else if (pick < 90) begin
            send_access(noise_item(MODE_PORT_READ, addr));
         end else if (pick < 94) begin
            send_access(noise_item(3'($urandom_range(MODE_ROM_LOAD + 1, MODE_UNUSED_LAST)), addr));
         end else begin
            send_access(noise_item(MODE_WRITE, addr));
         end
      end
   endtask

   initial begin
      reset            <= 1'b1;
      start            <= 1'b0;
      req_payload      <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data   <= 1'b0;
      bank_now    = 0;
      decrypt_now = 1'b0;
      burst_left  = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      write_decrypt(1'b0);
      directed_part();
      // alternate the decrypt flag between drained phases
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_for_results();
         write_decrypt(phase % 2 == 0);
         random_phase(PHASE_ITEMS);
      end
      wait_for_results();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

### sim.f
hw/rtl/bscmm_pkg.sv
hw/rtl/banked_sound_cpu_memory_map_unit.sv
sim/banked_sound_cpu_memory_map_checker.sv
sim/banked_sound_cpu_memory_map_unit_test.sv
